// ===== design/mdrd_pkg.sv =====
`default_nettype none
package mdrd_pkg;

    localparam int unsigned LEN_W      = 21;
    localparam int unsigned VALUE_W    = 28;
    localparam int unsigned RUN_W      = 16;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned MAX_LENGTH = 1048576;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LENGTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_ENABLE   = 2'd1;

    // descriptor kinds
    localparam logic [KIND_W-1:0] KIND_MASTER_INDEX = 3'd0;
    localparam logic [KIND_W-1:0] KIND_KEY_ID       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LITERAL      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LIT_MASTER   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FILL_RUN     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_COPY_RUN     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_END          = 3'd6;

    // count byte that escapes to a 16-bit run length
    localparam logic [7:0] ESC_COUNT = 8'h86;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [RUN_W-1:0]   run_length;
        logic               done_res;
        logic               missing_end;
    } t_desc;

endpackage
`default_nettype wire

// ===== design/mdrd_in_if.sv =====
`default_nettype none
interface mdrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface
`default_nettype wire

// ===== design/mdrd_out_if.sv =====
`default_nettype none
interface mdrd_out_if;
    logic                           valid;
    logic                           ready;
    logic [mdrd_pkg::KIND_W-1:0]    kind;
    logic [mdrd_pkg::VALUE_W-1:0]   value;
    logic [mdrd_pkg::RUN_W-1:0]     run_length;
    logic [mdrd_pkg::LEN_W-1:0]     position;
    logic                           done_res;
    logic                           missing_end;

    modport source (output valid, output kind, output value, output run_length,
                    output position, output done_res, output missing_end,
                    input ready);
    modport sink   (input valid, input kind, input value, input run_length,
                    input position, input done_res, input missing_end,
                    output ready);
endinterface
`default_nettype wire

// ===== design/mdrd_front.sv =====
`default_nettype none
module mdrd_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mdrd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mdrd_pkg::LEN_W-1:0]        i_cfg_data,
    mdrd_in_if.sink                                i_in,
    input  wire logic                              i_full,
    output logic                                   o_push,
    output mdrd_pkg::t_desc                        o_desc
);

    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_NUM_FIRST = 3'd1;
    localparam logic [2:0] PH_NUM_MORE  = 3'd2;
    localparam logic [2:0] PH_COUNT     = 3'd3;
    localparam logic [2:0] PH_LITERAL   = 3'd4;
    localparam logic [2:0] PH_ESC_LO    = 3'd5;
    localparam logic [2:0] PH_ESC_HI    = 3'd6;
    localparam logic [2:0] PH_FILL      = 3'd7;

    logic [mdrd_pkg::LEN_W-1:0]   r_exp_len;
    logic                         r_hdr_en;
    logic [2:0]                   r_ph, n_ph;
    logic [mdrd_pkg::LEN_W-1:0]   r_rem, n_rem;
    logic [6:0]                   r_lit, n_lit;
    logic [2:0]                   r_left, n_left;
    logic [mdrd_pkg::VALUE_W-1:0] r_acc, n_acc;
    logic                         r_hsec, n_hsec;
    logic [mdrd_pkg::RUN_W-1:0]   r_esc, n_esc;

    logic                         w_take;
    logic [7:0]                   w_b;
    logic                         w_start;
    logic [2:0]                   w_ph;
    logic [mdrd_pkg::LEN_W-1:0]   w_sat;
    logic [mdrd_pkg::LEN_W-1:0]   w_rem;
    logic                         w_hsec;
    logic [mdrd_pkg::VALUE_W-1:0] w_acc;
    logic [mdrd_pkg::VALUE_W-1:0] w_acc_shift;
    logic [6:0]                   w_lit_n;
    logic                         w_clip;
    logic [mdrd_pkg::RUN_W-1:0]   w_len;
    logic [mdrd_pkg::LEN_W-1:0]   w_rem_fill;
    logic [6:0]                   w_lit_dec;
    mdrd_pkg::t_desc              w_desc;
    logic                         w_push;

    assign i_in.ready = !i_full;
    assign w_take     = i_in.valid && !i_full;
    assign w_b        = i_in.stream_byte;

    // a new sequence reloads the length and header choice
    assign w_sat   = (r_exp_len > mdrd_pkg::MAX_LEN) ? mdrd_pkg::MAX_LEN : r_exp_len;
    assign w_start = (r_ph == PH_START);
    assign w_ph    = w_start ? (r_hdr_en ? PH_NUM_FIRST : PH_COUNT) : r_ph;
    assign w_rem   = w_start ? w_sat : r_rem;
    assign w_hsec  = w_start ? 1'b0 : r_hsec;
    assign w_acc   = w_start ? '0 : r_acc;

    assign w_acc_shift = {w_acc[mdrd_pkg::VALUE_W-9:0], w_b};

    assign w_lit_n = ({14'd0, w_b[6:0]} > w_rem) ? w_rem[6:0] : w_b[6:0];

    assign w_clip     = ({5'd0, r_esc} > w_rem);
    assign w_len      = w_clip ? w_rem[mdrd_pkg::RUN_W-1:0] : r_esc;
    assign w_rem_fill = w_rem - {5'd0, w_len};
    assign w_lit_dec  = r_lit - 7'd1;

    always_comb begin
        n_ph   = r_ph;
        n_rem  = r_rem;
        n_lit  = r_lit;
        n_left = r_left;
        n_acc  = r_acc;
        n_hsec = r_hsec;
        n_esc  = r_esc;
        w_push = 1'b0;
        w_desc = '0;
        if (w_take) begin
            n_ph   = w_ph;
            n_rem  = w_rem;
            n_hsec = w_hsec;
            n_acc  = w_acc;
            case (w_ph)
                PH_NUM_FIRST: begin
                    if (!w_b[7]) begin
                        w_push           = 1'b1;
                        w_desc.kind      = w_hsec ? mdrd_pkg::KIND_KEY_ID
                                                  : mdrd_pkg::KIND_MASTER_INDEX;
                        w_desc.value     = {20'd0, w_b};
                        n_acc            = '0;
                        n_left           = 3'd0;
                        n_hsec           = !w_hsec;
                        n_ph             = w_hsec ? PH_COUNT : PH_NUM_FIRST;
                    end else begin
                        n_ph = PH_NUM_MORE;
                        if (!w_b[6]) begin
                            n_acc  = {22'd0, w_b[5:0]};
                            n_left = 3'd1;
                        end else if (!w_b[5]) begin
                            n_acc  = {23'd0, w_b[4:0]};
                            n_left = 3'd2;
                        end else if (!w_b[4]) begin
                            n_acc  = {24'd0, w_b[3:0]};
                            n_left = 3'd3;
                        end else begin
                            n_acc  = '0;
                            n_left = 3'd4;
                        end
                    end
                end
                PH_NUM_MORE: begin
                    n_acc  = w_acc_shift;
                    n_left = r_left - 3'd1;
                    if (r_left == 3'd1) begin
                        w_push       = 1'b1;
                        w_desc.kind  = w_hsec ? mdrd_pkg::KIND_KEY_ID
                                              : mdrd_pkg::KIND_MASTER_INDEX;
                        w_desc.value = w_acc_shift;
                        n_acc        = '0;
                        n_hsec       = !w_hsec;
                        n_ph         = w_hsec ? PH_COUNT : PH_NUM_FIRST;
                    end
                end
                PH_COUNT: begin
                    if (w_b == 8'd0 || w_rem == '0) begin
                        w_push          = 1'b1;
                        w_desc.kind     = mdrd_pkg::KIND_END;
                        w_desc.done_res = 1'b1;
                        n_ph            = PH_START;
                        n_lit           = '0;
                        n_left          = '0;
                        n_acc           = '0;
                        n_hsec          = 1'b0;
                        n_esc           = '0;
                    end else if (!w_b[7]) begin
                        n_rem = w_rem - {14'd0, w_lit_n};
                        n_lit = w_lit_n;
                        n_ph  = PH_LITERAL;
                    end else if (w_b == mdrd_pkg::ESC_COUNT) begin
                        n_esc = '0;
                        n_ph  = PH_ESC_LO;
                    end else begin
                        n_esc = mdrd_pkg::RUN_W'(9'd256 - {1'b0, w_b});
                        n_ph  = PH_FILL;
                    end
                end
                PH_LITERAL: begin
                    w_push            = 1'b1;
                    w_desc.kind       = (w_b == 8'd0) ? mdrd_pkg::KIND_LIT_MASTER
                                                      : mdrd_pkg::KIND_LITERAL;
                    w_desc.value      = {20'd0, w_b};
                    w_desc.run_length = 16'd1;
                    n_lit             = w_lit_dec;
                    if (w_lit_dec == '0) begin
                        if (w_rem == '0) begin
                            w_desc.done_res = 1'b1;
                            n_ph            = PH_START;
                            n_left          = '0;
                            n_acc           = '0;
                            n_hsec          = 1'b0;
                            n_esc           = '0;
                        end else begin
                            n_ph = PH_COUNT;
                        end
                    end
                end
                PH_ESC_LO: begin
                    n_esc = {8'd0, w_b};
                    n_ph  = PH_ESC_HI;
                end
                PH_ESC_HI: begin
                    n_esc = {w_b, r_esc[7:0]};
                    n_ph  = PH_FILL;
                end
                default: begin
                    w_push             = 1'b1;
                    w_desc.kind        = (w_b == 8'd0) ? mdrd_pkg::KIND_COPY_RUN
                                                       : mdrd_pkg::KIND_FILL_RUN;
                    w_desc.value       = {20'd0, w_b};
                    w_desc.run_length  = w_len;
                    w_desc.missing_end = w_clip;
                    n_rem              = w_rem_fill;
                    n_esc              = '0;
                    if (w_rem_fill == '0) begin
                        w_desc.done_res = 1'b1;
                        n_ph            = PH_START;
                        n_lit           = '0;
                        n_left          = '0;
                        n_acc           = '0;
                        n_hsec          = 1'b0;
                    end else begin
                        n_ph = PH_COUNT;
                    end
                end
            endcase
        end
    end

    assign o_push = w_push;
    assign o_desc = w_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= 21'd1;
            r_hdr_en  <= 1'b1;
            r_ph      <= PH_START;
            r_rem     <= 21'd1;
            r_lit     <= '0;
            r_left    <= '0;
            r_acc     <= '0;
            r_hsec    <= 1'b0;
            r_esc     <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == mdrd_pkg::CFG_EXPECTED_LENGTH) begin
                r_exp_len <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == mdrd_pkg::CFG_HEADER_ENABLE) begin
                r_hdr_en <= i_cfg_data[0];
            end
            r_ph   <= n_ph;
            r_rem  <= n_rem;
            r_lit  <= n_lit;
            r_left <= n_left;
            r_acc  <= n_acc;
            r_hsec <= n_hsec;
            r_esc  <= n_esc;
        end
    end

endmodule
`default_nettype wire

// ===== design/mdrd_queue.sv =====
`default_nettype none
module mdrd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mdrd_pkg::t_desc i_desc,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output mdrd_pkg::t_desc      o_desc
);

    mdrd_pkg::t_desc r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_cnt;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule
`default_nettype wire

// ===== design/mdrd_back.sv =====
`default_nettype none
module mdrd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire mdrd_pkg::t_desc i_desc,
    output logic                 o_pop,
    mdrd_out_if.source           o_out
);

    logic                          r_valid;
    mdrd_pkg::t_desc               r_desc;
    logic [mdrd_pkg::LEN_W-1:0]    r_pos;
    logic [mdrd_pkg::LEN_W-1:0]    r_acc_pos;
    logic                          w_load;

    // take the next descriptor when the output register is free or drains
    assign w_load = i_valid && (!r_valid || o_out.ready);
    assign o_pop  = w_load;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_desc <= i_desc;
            r_pos  <= r_acc_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_acc_pos <= '0;
        end else begin
            if (w_load) begin
                r_valid   <= 1'b1;
                r_acc_pos <= i_desc.done_res ? '0
                           : r_acc_pos + {5'd0, i_desc.run_length};
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_desc.kind;
    assign o_out.value       = r_desc.value;
    assign o_out.run_length  = r_desc.run_length;
    assign o_out.position    = r_pos;
    assign o_out.done_res    = r_desc.done_res;
    assign o_out.missing_end = r_desc.missing_end;

endmodule
`default_nettype wire

// ===== design/master_delta_rle_decoder.sv =====
// master-delta run-length decoder, descriptor side
//
// i_in carries one compressed byte per transfer (valid/ready). o_out carries
// one descriptor per transfer: kind, value, run_length, position, done_res
// and missing_end. a byte yields zero or one descriptor.
// the config port writes expected_length (index 0) and header_enable
// (index 1) on any edge with i_cfg_we high; write it only while idle.
// both are sampled when the first byte of a sequence arrives.
// throughput: one byte per cycle while the queue is not full, set by the
// decode state update in the front section. a descriptor reaches o_out
// from the front through the two-entry descriptor queue and then the
// output register.
// when the receiver stalls, the output register holds, the queue fills,
// and i_in.ready drops once the queue holds two descriptors.
// synchronous active-low reset empties queue and output, restores
// expected_length = 1 and header_enable = 1, and starts a new sequence.
`default_nettype none
module master_delta_rle_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mdrd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mdrd_pkg::LEN_W-1:0]        i_cfg_data,
    mdrd_in_if.sink                                i_in,
    mdrd_out_if.source                             o_out
);

    // front to queue
    logic            w_push;
    mdrd_pkg::t_desc w_push_desc;
    logic            w_full;
    // queue to back
    logic            w_q_valid;
    mdrd_pkg::t_desc w_q_desc;
    logic            w_pop;

    // byte decode, header numbers, counts and remaining length
    mdrd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_desc      (w_push_desc)
    );

    // short descriptor queue so each side can stall on its own
    mdrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_desc  (w_q_desc)
    );

    // position tracking and the registered output
    mdrd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_desc  (w_q_desc),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
    import mdrd_pkg::*;

    // run control
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;        // front, queue and output register, with margin
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 150;      // bytes between two register settings
    localparam int MAX_REPORTS   = 40;

    // codes used by the stimulus
    localparam logic [7:0] END_COUNT = 8'h00;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // one expected descriptor, position included
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [RUN_W-1:0]   run_length;
        logic [LEN_W-1:0]   position;
        logic               done_res;
        logic               missing_end;
    } t_exp_desc;

    // decoder phases as the predictor tracks them
    typedef enum logic [2:0] {
        ST_START,
        ST_HDR_FIRST,
        ST_HDR_MORE,
        ST_COUNT,
        ST_LITERAL,
        ST_ESC_LO,
        ST_ESC_HI,
        ST_FILL
    } t_dec_state;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]   cfg_data;

    mdrd_in_if  in_if();
    mdrd_out_if out_if();

    master_delta_rle_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // predictor state: registers as last written, and the sequence being decoded
    logic [LEN_W-1:0]   cfg_len_cur;
    logic               cfg_hdr_cur;
    t_dec_state         dec_state;
    logic [LEN_W-1:0]   left_len;
    logic [6:0]         lit_left;
    logic [2:0]         num_left;
    logic [VALUE_W-1:0] num_acc;
    logic               key_next;
    logic [RUN_W-1:0]   esc_len;
    logic [LEN_W-1:0]   out_pos;

    // descriptors predicted but not yet seen on the output
    t_exp_desc pending_desc[$];

    int  err_cnt   = 0;
    int  bytes_sent = 0;
    int  cycle_cnt = 0;
    bit  idling_on;
    int  stall_left = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // back to the start of a sequence; position survives until the next start
    function void clear_sequence();
        dec_state = ST_START;
        lit_left  = '0;
        num_left  = '0;
        num_acc   = '0;
        key_next  = 1'b0;
        esc_len   = '0;
    endfunction

    function void predictor_reset();
        cfg_len_cur = LEN_W'(1);
        cfg_hdr_cur = 1'b1;
        left_len    = cfg_len_cur;
        out_pos     = '0;
        clear_sequence();
    endfunction

    // a complete header number: master index first, then key id
    function t_exp_desc header_number();
        t_exp_desc d;
        d          = '0;
        d.kind     = key_next ? KIND_KEY_ID : KIND_MASTER_INDEX;
        d.value    = num_acc;
        d.position = out_pos;
        num_acc    = '0;
        num_left   = '0;
        dec_state  = key_next ? ST_COUNT : ST_HDR_FIRST;
        key_next   = ~key_next;
        return d;
    endfunction

    // advance the decoder by one accepted byte, queue the descriptor it yields
    function void predict_descriptor(input logic [7:0] b);
        t_exp_desc        d;
        logic             produced;
        logic [LEN_W-1:0] take;
        d        = '0;
        produced = 1'b0;
        take     = '0;

        // registers are taken on the first byte of a sequence
        if (dec_state == ST_START) begin
            left_len  = (cfg_len_cur > MAX_LEN) ? MAX_LEN : cfg_len_cur;
            out_pos   = '0;
            key_next  = 1'b0;
            num_acc   = '0;
            dec_state = cfg_hdr_cur ? ST_HDR_FIRST : ST_COUNT;
        end

        case (dec_state)
            ST_HDR_FIRST: begin
                if (!b[7]) begin
                    num_acc  = VALUE_W'(b);
                    d        = header_number();
                    produced = 1'b1;
                end else begin
                    if (!b[6]) begin
                        num_acc  = VALUE_W'(b[5:0]);
                        num_left = 3'd1;
                    end else if (!b[5]) begin
                        num_acc  = VALUE_W'(b[4:0]);
                        num_left = 3'd2;
                    end else if (!b[4]) begin
                        num_acc  = VALUE_W'(b[3:0]);
                        num_left = 3'd3;
                    end else begin
                        // longest form: first byte carries no bits
                        num_acc  = '0;
                        num_left = 3'd4;
                    end
                    dec_state = ST_HDR_MORE;
                end
            end
            ST_HDR_MORE: begin
                num_acc  = {num_acc[VALUE_W-9:0], b};
                num_left = num_left - 3'd1;
                if (num_left == 3'd0) begin
                    d        = header_number();
                    produced = 1'b1;
                end
            end
            ST_COUNT: begin
                if (b == END_COUNT || left_len == '0) begin
                    d.kind     = KIND_END;
                    d.position = out_pos;
                    d.done_res = 1'b1;
                    produced   = 1'b1;
                    clear_sequence();
                end else if (!b[7]) begin
                    // literal count, clipped to what is left
                    take      = (LEN_W'(b) > left_len) ? left_len : LEN_W'(b);
                    left_len  = left_len - take;
                    lit_left  = take[6:0];
                    dec_state = ST_LITERAL;
                end else if (b == ESC_COUNT) begin
                    esc_len   = '0;
                    dec_state = ST_ESC_LO;
                end else begin
                    esc_len   = RUN_W'(9'h100 - {1'b0, b});
                    dec_state = ST_FILL;
                end
            end
            ST_LITERAL: begin
                d.kind       = (b == 8'h00) ? KIND_LIT_MASTER : KIND_LITERAL;
                d.value      = VALUE_W'(b);
                d.run_length = RUN_W'(1);
                d.position   = out_pos;
                produced     = 1'b1;
                out_pos      = out_pos + LEN_W'(1);
                lit_left     = lit_left - 7'd1;
                if (lit_left == 7'd0) begin
                    if (left_len == '0) begin
                        d.done_res = 1'b1;
                        clear_sequence();
                    end else begin
                        dec_state = ST_COUNT;
                    end
                end
            end
            ST_ESC_LO: begin
                esc_len   = RUN_W'(b);
                dec_state = ST_ESC_HI;
            end
            ST_ESC_HI: begin
                esc_len   = {b, esc_len[7:0]};
                dec_state = ST_FILL;
            end
            ST_FILL: begin
                take = LEN_W'(esc_len);
                if (take > left_len) begin
                    take          = left_len;
                    d.missing_end = 1'b1;
                end
                left_len     = left_len - take;
                d.kind       = (b == 8'h00) ? KIND_COPY_RUN : KIND_FILL_RUN;
                d.value      = VALUE_W'(b);
                d.run_length = RUN_W'(take);
                d.position   = out_pos;
                produced     = 1'b1;
                out_pos      = out_pos + take;
                esc_len      = '0;
                if (left_len == '0) begin
                    d.done_res = 1'b1;
                    clear_sequence();
                end else begin
                    dec_state = ST_COUNT;
                end
            end
            default: ;
        endcase

        if (produced)
            pending_desc.push_back(d);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // every output transfer is compared with the oldest prediction
    always @(posedge i_clk) begin : desc_check
        t_exp_desc want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_desc.size() == 0) begin
                report_mismatch($sformatf("unexpected descriptor kind %0d pos %0d",
                                          out_if.kind, out_if.position));
            end else begin
                want = pending_desc.pop_front();
                if (out_if.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d (pos %0d)",
                                              out_if.kind, want.kind, want.position));
                if (out_if.value !== want.value)
                    report_mismatch($sformatf("value %0h, want %0h (pos %0d)",
                                              out_if.value, want.value, want.position));
                if (out_if.run_length !== want.run_length)
                    report_mismatch($sformatf("run_length %0d, want %0d (pos %0d)",
                                              out_if.run_length, want.run_length,
                                              want.position));
                if (out_if.position !== want.position)
                    report_mismatch($sformatf("position %0d, want %0d",
                                              out_if.position, want.position));
                if (out_if.done_res !== want.done_res)
                    report_mismatch($sformatf("done_res %0b, want %0b (pos %0d)",
                                              out_if.done_res, want.done_res,
                                              want.position));
                if (out_if.missing_end !== want.missing_end)
                    report_mismatch($sformatf("missing_end %0b, want %0b (pos %0d)",
                                              out_if.missing_end, want.missing_end,
                                              want.position));
            end
        end
    end

    // receiver: ready drops in bursts of random length while idling is on
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(0, 8);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus primitives
    // ------------------------------------------------------------------

    // one byte transfer; valid stays high into the next call unless a gap comes
    task automatic send_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_if.valid       <= 1'b0;
            in_if.stream_byte <= 8'($urandom);   // junk while valid is low
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.stream_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_descriptor(b);
        bytes_sent++;
    endtask

    // register writes back to back, index 0 then 1, optionally a spare index
    task automatic write_config(input logic [LEN_W-1:0] len_val,
                               input logic [LEN_W-1:0] hdr_val,
                               input bit poke_spare);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_LENGTH;
        cfg_data  <= len_val;
        @(posedge i_clk);
        cfg_len_cur = len_val;
        cfg_index <= CFG_HEADER_ENABLE;
        cfg_data  <= hdr_val;
        @(posedge i_clk);
        cfg_hdr_cur = hdr_val[0];
        if (poke_spare) begin
            // writes beyond the two registers must change nothing
            cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
            cfg_data  <= LEN_W'($urandom);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // wait until every predicted descriptor is out, then let the pipe settle
    task automatic wait_for_descriptors();
        in_if.valid <= 1'b0;
        while (pending_desc.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // prefix-coded header number in 1 to 5 bytes
    task automatic send_number(input logic [31:0] v, input int nbytes);
        case (nbytes)
            1: send_byte({1'b0, v[6:0]});
            2: begin
                send_byte({2'b10, v[13:8]});
                send_byte(v[7:0]);
            end
            3: begin
                send_byte({3'b110, v[20:16]});
                send_byte(v[15:8]);
                send_byte(v[7:0]);
            end
            4: begin
                send_byte({4'b1110, v[27:24]});
                send_byte(v[23:16]);
                send_byte(v[15:8]);
                send_byte(v[7:0]);
            end
            default: begin
                // low nibble of the lead byte is ignored, top nibble of v gets masked
                send_byte({4'b1111, 4'($urandom)});
                send_byte(v[31:24]);
                send_byte(v[23:16]);
                send_byte(v[15:8]);
                send_byte(v[7:0]);
            end
        endcase
    endtask

    function logic [7:0] pick_fill();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    // literal block; the byte count follows the clipped count
    task automatic send_literal_block();
        int n;
        n = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 16) : $urandom_range(17, 127);
        send_byte(8'(n));
        while (dec_state == ST_LITERAL)
            send_byte(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom));
    endtask

    // run with a one-byte negative count
    task automatic send_short_run();
        int          len;
        logic [7:0]  cnt;
        len = $urandom_range(1, 128);
        cnt = 8'(256 - len);
        if (cnt == ESC_COUNT)
            cnt = cnt + 8'd1;
        send_byte(cnt);
        if (dec_state != ST_FILL)
            return;
        send_byte(pick_fill());
    endtask

    // run with an escaped 16-bit length
    task automatic send_escape_run();
        logic [15:0] len;
        case ($urandom_range(0, 9))
            0:       len = 16'h0000;
            1:       len = 16'hFFFF;
            2, 3, 4: len = 16'($urandom);
            default: len = 16'($urandom_range(1, 300));
        endcase
        send_byte(ESC_COUNT);
        if (dec_state != ST_ESC_LO)
            return;
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(pick_fill());
    endtask

    // a well-formed sequence with random content, run until it closes
    task automatic send_sequence();
        int pick;
        if (dec_state == ST_START && cfg_hdr_cur) begin
            send_number($urandom, $urandom_range(1, 5));
            send_number($urandom, $urandom_range(1, 5));
        end
        do begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_byte(END_COUNT);
            else if (pick < 50)
                send_literal_block();
            else if (pick < 72)
                send_short_run();
            else
                send_escape_run();
        end while (dec_state != ST_START);
    endtask

    // random bytes that may break a sequence anywhere
    task automatic send_noise();
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    endtask

    // mostly short lengths, now and then the extremes
    task automatic random_config();
        logic [LEN_W-1:0] len;
        case ($urandom_range(0, 19))
            0:       len = '0;
            1:       len = MAX_LEN;
            2:       len = '1;
            3:       len = LEN_W'($urandom);
            default: len = LEN_W'($urandom_range(1, 300));
        endcase
        write_config(len, LEN_W'($urandom), $urandom_range(0, 3) == 0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // five-byte and one-byte numbers, both literal kinds, a master copy run
    // that closes the sequence on the last position
    task automatic test_headers_and_literals();
        write_config(LEN_W'(3), LEN_W'(1), 1'b1);
        repeat (5) send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_for_descriptors();
    endtask

    // no header, length saturated, zero-length escape run, longest short
    // run, explicit end
    task automatic test_runs_without_header();
        write_config('1, LEN_W'(0), 1'b0);
        send_byte(ESC_COUNT);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h5A);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(END_COUNT);
        wait_for_descriptors();
    endtask

    // zero length: the first count byte ends the sequence whatever it is,
    // after a two-byte and a three-byte number
    task automatic test_zero_length();
        write_config(LEN_W'(0), LEN_W'(1), 1'b0);
        send_byte(8'hBF);
        send_byte(8'hFF);
        send_byte(8'hDF);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h7F);
        wait_for_descriptors();
    endtask

    // longest escaped run against a short sequence: clipped and flagged
    task automatic test_run_overrun();
        write_config(LEN_W'(5), LEN_W'(0), 1'b1);
        send_byte(ESC_COUNT);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hAA);
        wait_for_descriptors();
    endtask

    // random sequences in phases, registers rewritten between phases
    task automatic test_random_streams(input int byte_budget, input bit with_idling);
        int stop_at;
        int phase_end;
        idling_on <= with_idling;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at) begin
            random_config();
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end && bytes_sent < stop_at) begin
                if ($urandom_range(0, 19) == 0)
                    send_noise();
                else
                    send_sequence();
            end
            wait_for_descriptors();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        in_if.valid       <= 1'b0;
        in_if.stream_byte <= 8'h00;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_EXPECTED_LENGTH;
        cfg_data          <= '0;
        idling_on         <= 1'b1;
        i_rst_n           <= 1'b0;
        predictor_reset();

        // synchronous reset, held low before it is released
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_headers_and_literals();
        test_runs_without_header();
        test_zero_length();
        test_run_overrun();
        test_random_streams(1000, 1'b1);
        // tail of the run at full rate on both sides
        test_random_streams(250, 1'b0);

        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== master_delta_rle_decoder.f =====
design/mdrd_pkg.sv
design/mdrd_in_if.sv
design/mdrd_out_if.sv
design/mdrd_front.sv
design/mdrd_queue.sv
design/mdrd_back.sv
design/master_delta_rle_decoder.sv
tb/tb_top.sv
